// ===== rtl/core/cdmf_pkg.sv =====
package cdmf_pkg;

  localparam int unsigned HashBits = 20;
  localparam int unsigned SlotBits = HashBits - 3;
  localparam int unsigned MapBytes = 1 << SlotBits;

  localparam logic [31:0] CrcPoly   = 32'hEDB88320;
  localparam logic [31:0] CrcPreset = 32'hFFFFFFFF;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrBits   = $clog2(QueueDepth);
  localparam int unsigned QCntBits   = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        seen_before;
    logic [31:0] message_crc;
  } out_word_t;

  typedef struct packed {
    logic [31:0] crc;
  } msg_word_t;

  typedef struct packed {
    logic clearing;
    logic queue_full;
  } front_ctrl_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } back_state_e;

  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] r;
    r = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/cdmf_front.sv =====
module cdmf_front
  import cdmf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  input  front_ctrl_t ctrl_i,
  output logic        push_o,
  output msg_word_t   push_word_o
);

  logic [31:0] crc_q, crc_d;
  logic [31:0] folded;
  logic        accept;

  assign in_ready_o = !ctrl_i.clearing && !ctrl_i.queue_full;
  assign accept     = in_valid_i && in_ready_o;
  assign folded     = crc_fold(crc_q, in_word_i.data_byte);

  always_comb begin
    crc_d = crc_q;
    if (accept) begin
      crc_d = in_word_i.last_byte ? CrcPreset : folded;
    end
  end

  assign push_o          = accept && in_word_i.last_byte;
  assign push_word_o.crc = ~folded;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcPreset;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

// ===== rtl/core/cdmf_queue.sv =====
module cdmf_queue
  import cdmf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  msg_word_t push_word_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output msg_word_t pop_word_o
);

  msg_word_t             slot_q [QueueDepth];
  logic [QPtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntBits-1:0]   count_q, count_d;

  assign full_o     = (count_q == QCntBits'(QueueDepth));
  assign valid_o    = (count_q != '0);
  assign pop_word_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPtrBits'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPtrBits'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCntBits'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/core/cdmf_back.sv =====
module cdmf_back
  import cdmf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  msg_word_t q_word_i,
  output logic      pop_o,
  output logic      clearing_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  back_state_e state_q, state_d;
  logic [SlotBits-1:0] clr_addr_q, clr_addr_d;

  logic [7:0] map_q [0:MapBytes-1];
  logic [7:0] rdata_q;

  logic                b_valid_q, b_valid_d;
  logic [31:0]         b_crc_q;
  logic [SlotBits-1:0] b_slot_q;
  logic [2:0]          b_bit_q;
  logic                fwd_q;
  logic [7:0]          fwd_data_q;

  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;

  logic                advance, b_fire, pop;
  logic [SlotBits-1:0] pop_slot;
  logic [7:0]          cur_byte, merged;
  logic                seen;
  logic                wr_en;
  logic [SlotBits-1:0] wr_addr;
  logic [7:0]          wr_data;

  assign advance  = !out_valid_q || out_ready_i;
  assign b_fire   = b_valid_q && advance;
  assign pop      = (state_q == ST_RUN) && q_valid_i && (!b_valid_q || advance);
  assign pop_slot = q_word_i.crc[HashBits-1:3];

  assign cur_byte = fwd_q ? fwd_data_q : rdata_q;
  assign seen     = cur_byte[b_bit_q];
  assign merged   = cur_byte | (8'd1 << b_bit_q);

  assign wr_en   = (state_q == ST_CLEAR) || b_fire;
  assign wr_addr = (state_q == ST_CLEAR) ? clr_addr_q : b_slot_q;
  assign wr_data = (state_q == ST_CLEAR) ? 8'd0 : merged;

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + SlotBits'(1);
        if (clr_addr_q == {SlotBits{1'b1}}) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    b_valid_d = b_valid_q;
    if (pop) begin
      b_valid_d = 1'b1;
    end else if (b_fire) begin
      b_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (b_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // bitmap: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_q[wr_addr] <= wr_data;
    end
    if (pop) begin
      rdata_q <= map_q[pop_slot];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_crc_q    <= q_word_i.crc;
      b_slot_q   <= pop_slot;
      b_bit_q    <= q_word_i.crc[2:0];
      fwd_q      <= b_fire && (b_slot_q == pop_slot);
      fwd_data_q <= merged;
    end
    if (b_fire) begin
      out_word_q.seen_before <= seen;
      out_word_q.message_crc <= b_crc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign pop_o       = pop;
  assign clearing_o  = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== rtl/core/crc32_duplicate_message_filter_core.sv =====
// channel   handshake              word        moves
// in        in_valid_i/in_ready_o  in_word_i   one message byte, last_byte marks the end
// out       out_valid_o/out_ready_i out_word_o one word per message: seen_before, message_crc
//
// one byte per cycle while in_ready_o is high; the crc fold of a byte is done in the front part
// a message word leaves after its last byte by way of the queue,
// the registered bitmap read and the output register
// after reset the bitmap of 2^(HashBits-3) = 131072 bytes is cleared one byte a cycle,
// with in_ready_o low
// a stall on the output fills the four-entry queue before in_ready_o drops
module crc32_duplicate_message_filter_core
  import cdmf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  front_ctrl_t ctrl;
  logic        push, pop, q_full, q_valid, clearing;
  msg_word_t   push_word, pop_word;

  assign ctrl.clearing   = clearing;
  assign ctrl.queue_full = q_full;

  cdmf_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_word_i,
    .ctrl_i      (ctrl),
    .push_o      (push),
    .push_word_o (push_word)
  );

  cdmf_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .pop_word_o  (pop_word)
  );

  cdmf_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i   (q_valid),
    .q_word_i    (pop_word),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o,
    .out_ready_i,
    .out_word_o
  );

endmodule

// ===== rtl/core/cdmf_checker.sv =====
module cdmf_checker
  import cdmf_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // a waiting input word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_word_i))
    else $error("input word dropped or changed while waiting");

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word dropped or changed while stalled");

  // bitmap clearing keeps the input closed right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !in_ready_o)
    else $error("input open before bitmap clear");

  // nothing comes out right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |=> !out_valid_o)
    else $error("output word without a message");

  // no output word can appear while still clearing with nothing accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && $past(!in_ready_o) && $past(!out_valid_o) |-> !$rose(out_valid_o)
      || $past(in_ready_o, 2) || $past(in_ready_o, 3))
    else $error("output word appeared during bitmap clear");

endmodule

bind crc32_duplicate_message_filter_core cdmf_checker u_cdmf_checker (.*);

// ===== verif/crc32_duplicate_message_filter_core_tb.sv =====
module crc32_duplicate_message_filter_core_tb;
  import cdmf_pkg::*;

  typedef struct {
    logic [7:0]  data_byte;
    logic        last_byte;
    bit          pinned;
    logic        seen_before;
    logic [31:0] message_crc;
  } byte_row_t;

  localparam int unsigned RandomBytes = 1400;
  localparam int unsigned NumPhases   = 4;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  logic [31:0] shadow_crc;
  bit          hash_marks [logic [31:0]];
  out_word_t   pending_words [$];
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  logic [7:0]  msg_pool [$];
  int unsigned msg_start [$];
  int unsigned msg_len [$];

  byte_row_t   byte_rows [23];

  crc32_duplicate_message_filter_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] crc_step(input logic [31:0] reg_val, input logic [7:0] b);
    logic [31:0] r;
    r = reg_val ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
    end
    return r;
  endfunction

  // folds one byte; on the last byte, looks up and records the hash
  function automatic bit filter_predict(input in_word_t w, output out_word_t res);
    logic [31:0] folded;
    logic [31:0] final_crc;
    logic [31:0] hash;
    folded = crc_step(shadow_crc, w.data_byte);
    res = '0;
    if (!w.last_byte) begin
      shadow_crc = folded;
      return 1'b0;
    end
    final_crc = ~folded;
    shadow_crc = 32'hFFFFFFFF;
    hash = 32'(64'(final_crc) & ((64'd1 << HashBits) - 64'd1));
    res.message_crc = final_crc;
    if (hash_marks.exists(hash)) begin
      res.seen_before = 1'b1;
    end else begin
      hash_marks[hash] = 1'b1;
      res.seen_before = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input bit pinned,
                           input logic exp_seen, input logic [31:0] exp_crc);
    in_word_t  w;
    out_word_t res;
    w.data_byte = b;
    w.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    if (filter_predict(w, res)) begin
      if (pinned) begin
        res.seen_before = exp_seen;
        res.message_crc = exp_crc;
      end
      pending_words.push_back(res);
    end
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected word: seen %0b crc %08h", got.seen_before, got.message_crc);
      end
      return;
    end
    want = pending_words.pop_front();
    if (got.seen_before !== want.seen_before || got.message_crc !== want.message_crc) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("word mismatch: expected seen %0b crc %08h, got seen %0b crc %08h",
                 want.seen_before, want.message_crc, got.seen_before, got.message_crc);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_word(out_word);
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  b;

    in_valid       = 1'b0;
    in_word        = '0;
    out_ready      = 1'b0;
    rst_n          = 1'b0;
    shadow_crc     = 32'hFFFFFFFF;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    byte_rows = '{
      '{8'h00, 1'b1, 1'b1, 1'b0, 32'hD202EF8D},
      '{8'h00, 1'b1, 1'b1, 1'b1, 32'hD202EF8D},
      '{8'hFF, 1'b1, 1'b1, 1'b0, 32'hFF000000},
      '{8'h31, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h32, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h33, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h34, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h35, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h36, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h37, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h38, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h39, 1'b1, 1'b1, 1'b0, 32'hCBF43926},
      '{8'h31, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h32, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h33, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h34, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h35, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h36, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h37, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h38, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h39, 1'b1, 1'b1, 1'b1, 32'hCBF43926},
      '{8'hFF, 1'b1, 1'b1, 1'b1, 32'hFF000000},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 32'h0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (byte_rows[i]) begin
      send_byte(byte_rows[i].data_byte, byte_rows[i].last_byte, byte_rows[i].pinned,
                byte_rows[i].seen_before, byte_rows[i].message_crc);
    end
    // close the message left open by the last row
    send_byte(8'h00, 1'b1, 1'b0, 1'b0, 32'h0);

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      sent = 0;
      while (sent < RandomBytes / NumPhases) begin
        if (msg_len.size() != 0 && $urandom_range(99) < 25) begin
          // replay an earlier message
          pick = $urandom_range(msg_len.size() - 1);
          for (int unsigned k = 0; k < msg_len[pick]; k++) begin
            send_byte(msg_pool[msg_start[pick] + k], k == msg_len[pick] - 1, 1'b0, 1'b0, 32'h0);
          end
          sent += msg_len[pick];
        end else begin
          len = ($urandom_range(99) < 90) ? $urandom_range(1, 6) : $urandom_range(7, 40);
          msg_start.push_back(msg_pool.size());
          msg_len.push_back(len);
          for (int unsigned k = 0; k < len; k++) begin
            b = 8'($urandom_range(255));
            msg_pool.push_back(b);
            send_byte(b, k == len - 1, 1'b0, 1'b0, 32'h0);
          end
          sent += len;
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
